FILE: sv/swm_pkg.sv
// Package with the shared types and constants of the sliding window median filter.
`default_nettype none

package swm_pkg;

   // Deepest window the cell row can hold.
   localparam int MAX_WINDOW = 64;

   // Width of a cell index and of an entry's age tag.
   localparam int IDX_W = $clog2(MAX_WINDOW);

   // Width of a window length or an entry count, which may equal MAX_WINDOW.
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   // Fixed field widths of the streams and of the window length register.
   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = SAMPLE_W + 1;
   localparam int LEN_W    = 7;

   // Operation that every cell performs in the current cycle.
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_PRUNE  = 2'd1;
   localparam logic [1:0] OP_SHIFT  = 2'd2;
   localparam logic [1:0] OP_INSERT = 2'd3;

   // Contents of one cell: a stored sample, its age and whether it holds one.
   typedef struct packed {
      logic                       valid;
      logic [IDX_W-1:0]           age;
      logic signed [SAMPLE_W-1:0] value;
   } cell_data_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic [1:0]                 op;
      logic                       clear;
      logic [CNT_W-1:0]           win;
      logic signed [SAMPLE_W-1:0] sample;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/swm_cell.sv
// One cell of the sorted row: holds one entry and trades it with its neighbors.
`default_nettype none

module swm_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire swm_pkg::cell_ctrl_type ctrl,
   input  wire swm_pkg::cell_data_type left_q,
   input  wire swm_pkg::cell_data_type right_q,
   input  wire logic                   le_in,
   input  wire logic                   gap_in,
   output swm_pkg::cell_data_type      data_q,
   output logic                        le_out,
   output logic                        gap_out
);

   swm_pkg::cell_data_type data_ff;
   swm_pkg::cell_data_type data_in;
   logic                   keep_age;

   // This entry sorts at or below the new sample; true for a prefix of the row.
   assign le_out  = data_ff.valid && (data_ff.value <= ctrl.sample);
   // Some cell at or left of this one is empty.
   assign gap_out = gap_in || !data_ff.valid;

   assign keep_age = (swm_pkg::CNT_W'(data_ff.age) + swm_pkg::CNT_W'(1)) < ctrl.win;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         swm_pkg::OP_PRUNE: begin
            data_in.valid = data_ff.valid && !ctrl.clear && keep_age;
            data_in.age   = data_ff.age + swm_pkg::IDX_W'(1);
         end
         swm_pkg::OP_SHIFT: begin
            if (gap_out) begin
               data_in = right_q;
            end
         end
         swm_pkg::OP_INSERT: begin
            if (!le_out) begin
               if (le_in) begin
                  data_in.valid = 1'b1;
                  data_in.age   = '0;
                  data_in.value = ctrl.sample;
               end else begin
                  data_in = left_q;
               end
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Only the valid flag needs a reset; the payload of an empty cell is never used.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.age   <= data_in.age;
      data_ff.value <= data_in.value;
   end

   assign data_q = data_ff;

endmodule

`default_nettype wire

FILE: sv/sliding_window_median.sv
// Sliding window median filter: a row of sorting cells with a small sequencer.
// Sequence: the accepting edge ages and prunes the window, compaction closes the holes
// left by dropped entries, the new sample is inserted, and select loads the result register.
// A new sample beat is taken only once the sequencer is back in idle; select also waits while
// the previous result is still unread, holding off the next sample beat.
// Reset empties the window and sets the window length to three.
`default_nettype none

module sliding_window_median (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] sample
   input  wire logic        req_tuser,   // [0] start_new
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [32:0] median_twice, [39:33] zero
   // Window length register.
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data  // [6:0] window_len
);

   localparam int NCELL = swm_pkg::MAX_WINDOW;
   localparam int IDX_W = swm_pkg::IDX_W;
   localparam int CNT_W = swm_pkg::CNT_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COMPACT = 2'd1;
   localparam logic [1:0] ST_SELECT  = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [swm_pkg::LEN_W-1:0]           window_len_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                out_valid_ff;
   logic signed [swm_pkg::MEDIAN_W-1:0] out_data_ff, out_data_in;

   logic                   req_accept;
   logic                   out_load;
   logic [CNT_W-1:0]       win;
   swm_pkg::cell_ctrl_type ctrl;
   swm_pkg::cell_data_type cell_q [NCELL];
   swm_pkg::cell_data_type empty_cell;
   logic [NCELL:0]         le_chain;
   logic [NCELL:0]         gap_chain;
   logic [NCELL:0]         valid_vec;
   logic                   need_shift;
   logic                   emit;
   logic [IDX_W-1:0]       lo_idx, hi_idx;

   // The register accepts any code; zero behaves as a window of one and
   // anything above the row depth saturates to the full row.
   always_comb begin
      if (window_len_ff == '0) begin
         win = CNT_W'(1);
      end else if (CNT_W'(window_len_ff) > CNT_W'(NCELL)) begin
         win = CNT_W'(NCELL);
      end else begin
         win = CNT_W'(window_len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= swm_pkg::LEN_W'(3);
      end else if (csr_wr_en) begin
         window_len_ff <= csr_wr_data;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= $signed(req_tdata);
      end
   end

   // Empty entries are fed in at the ends of the row.
   assign empty_cell = '0;

   // Every cell sees the same operation. On the accept beat the cells age
   // their entries and drop those that leave the window (all of them when
   // start_new is set). Afterwards the row closes one gap per cycle until it
   // is dense, and then the new sample is inserted at its sorted place.
   always_comb begin
      ctrl.clear  = req_tuser;
      ctrl.win    = win;
      ctrl.sample = sample_ff;
      ctrl.op     = swm_pkg::OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ctrl.op = swm_pkg::OP_PRUNE;
            end
         end
         ST_COMPACT: begin
            ctrl.op = need_shift ? swm_pkg::OP_SHIFT : swm_pkg::OP_INSERT;
         end
         default: begin
            ctrl.op = swm_pkg::OP_HOLD;
         end
      endcase
   end

   assign le_chain[0]  = 1'b1;
   assign gap_chain[0] = 1'b0;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      swm_pkg::cell_data_type left_q, right_q;
      if (i == 0) begin : g_first
         assign left_q = empty_cell;
      end else begin : g_left
         assign left_q = cell_q[i-1];
      end
      if (i == NCELL - 1) begin : g_last
         assign right_q = empty_cell;
      end else begin : g_right
         assign right_q = cell_q[i+1];
      end

      swm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .left_q  (left_q),
         .right_q (right_q),
         .le_in   (le_chain[i]),
         .gap_in  (gap_chain[i]),
         .data_q  (cell_q[i]),
         .le_out  (le_chain[i+1]),
         .gap_out (gap_chain[i+1])
      );

      assign valid_vec[i] = cell_q[i].valid;
   end

   assign valid_vec[NCELL] = 1'b0;

   // A gap remains while some empty cell has an occupied cell to its right.
   always_comb begin
      need_shift = 1'b0;
      for (int i = 0; i < NCELL - 1; i++) begin
         need_shift = need_shift || (!valid_vec[i] && valid_vec[i+1]);
      end
   end

   // The dense row is full when exactly the first win cells are occupied.
   assign emit   = valid_vec[win - CNT_W'(1)] && !valid_vec[win];
   assign lo_idx = IDX_W'((win - CNT_W'(1)) >> 1);
   assign hi_idx = IDX_W'(win >> 1);

   // Twice the median is the sum of the lower and upper middle entries.
   assign out_data_in = swm_pkg::MEDIAN_W'(cell_q[lo_idx].value)
                      + swm_pkg::MEDIAN_W'(cell_q[hi_idx].value);

   // The select step waits only when a result is due and the previous one
   // has not been taken yet.
   assign out_load = (state_ff == ST_SELECT) && emit && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            if (!need_shift) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (!emit || out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(40 - swm_pkg::MEDIAN_W){1'b0}}, out_data_ff};

   // An accepted sample always moves the sequencer on to compaction.
   a_accept_compacts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_COMPACT))
      else $error("accepted sample did not start compaction");

   // After insertion the row is dense and its first cell is occupied.
   a_select_dense: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SELECT) |-> (!need_shift && valid_vec[0]))
      else $error("cell row not dense after insertion");

   // A result enters the output register only when it is free or draining.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   // A loaded result is offered on the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("loaded result not offered");

endmodule

`default_nettype wire
